// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// constants and helper functions shared by the stream hash unit
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CountW = 61;

	localparam logic [WordW-1:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WordW-1:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef logic [WordW-1:0] word_t;

	// control between the sequencer and the compression core
	typedef struct packed {
		logic start;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t big0(input word_t x);
		big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big1(input word_t x);
		big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// 64-round compression; message words stream from the block memory, the
// schedule window lives in two 16-entry copies, each read twice per round
// ----------------------------------------------------------------------------
`default_nettype none
module sha_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha_pkg::core_ctl_t ctl,
	output sha_pkg::core_sts_t     sts,
	// block memory read port (word address)
	output logic [3:0]             blk_addr,
	input  wire sha_pkg::word_t    blk_word,
	// hash words
	input  wire sha_pkg::word_t    hash_in [8],
	output sha_pkg::word_t         hash_out [8],
	output logic                   hash_we
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ADD} state_t;

	state_t         state_q;
	logic [6:0]     cnt_q;      // pipeline slot counter; the round in flight is its registered copy rnd_s1
	sha_pkg::word_t v_q [8];

	// schedule window memory: four read ports via dual copies
	sha_pkg::word_t wa_mem [16];
	sha_pkg::word_t wb_mem [16];
	sha_pkg::word_t w2_q, w7_q, w15_q, w16_q;
	sha_pkg::word_t w2_r, w7_r;
	logic [5:0]     rnd_s1;
	logic           vld_s1;

	logic [5:0] rnd_c;
	assign rnd_c = cnt_q[5:0];
	assign blk_addr = rnd_c[3:0];

	// read addresses for round rnd_c, data used next cycle
	always_ff @(posedge clk) begin
		w15_q <= wa_mem[4'(rnd_c - 6'd15)];
		w16_q <= wa_mem[rnd_c[3:0]];
		w2_r  <= wb_mem[4'(rnd_c - 6'd2)];
		w7_r  <= wb_mem[4'(rnd_c - 6'd7)];
	end

	// word of round r-2 is committed to the window memories before the read for round r
	sha_pkg::word_t w_new;

	assign w2_q = w2_r;
	assign w7_q = w7_r;

	always_comb begin
		if (rnd_s1 < 6'd16) begin
			w_new = blk_word;
		end else begin
			w_new = sha_pkg::sig1(w2_q) + w7_q + sha_pkg::sig0(w15_q) + w16_q;
		end
	end

	sha_pkg::word_t t1, t2;
	always_comb begin
		t1 = v_q[7] + sha_pkg::big1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::ROUND_K[rnd_s1] + w_new;
		t2 = sha_pkg::big0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
			^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			wa_mem[rnd_s1[3:0]] <= w_new;
			wb_mem[rnd_s1[3:0]] <= w_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			vld_s1   <= 1'b0;
			rnd_s1   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (ctl.start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					vld_s1 <= !cnt_q[6];
					rnd_s1 <= rnd_c;
					if (!cnt_q[6]) begin
						cnt_q <= cnt_q + 7'd1;
					end else begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					vld_s1  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ctl.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= hash_in[i];
		end else if (vld_s1) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) hash_out[i] = hash_in[i] + v_q[i];
	end

	assign hash_we   = (state_q == ST_ADD);
	assign sts.busy  = (state_q != ST_IDLE);
	assign sts.done  = (state_q == ST_ADD);

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == ST_IDLE) else $error("start while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> $past(cnt_q[6])) else $error("early add");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == ST_RUN || state_q == ST_ADD) else $error("stray round");

endmodule
`default_nettype wire

// ===== rtl/sha256_stream_hash_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hash_unit
// byte stream SHA-256 with block memory, compression core and digest output
// ----------------------------------------------------------------------------
// channel  | signals                            | dir
// request  | valid ready command data_byte      | in
// digest   | out_valid out_ready digest_word,   | out
//          | word_index last_word               |
// an absorb request writes one byte; the 64th byte of a block starts the
// compression core (one round per cycle; rounds 0-15 read the block memory)
// a finish request writes 0x80, zero padding and the length, runs one or two
// compressions, then eight digest words straight from the hash register
// reset is asynchronous and restores the initial hash; no clearing pass
// requests are held off while padding, compressing or emitting the digest
`default_nettype none
module sha256_stream_hash_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             ready,
	input  wire logic        command,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	typedef enum logic [2:0] {ST_IDLE, ST_COMP, ST_PAD, ST_LEN, ST_FCOMP, ST_EMIT} state_t;

	state_t                     state_q;
	logic [sha_pkg::CountW-1:0] count_q;
	logic [5:0]                 fill_q;
	logic                       two_q;
	sha_pkg::word_t             hash_q [8];
	logic [2:0]                 len_q;

	// block memory: 16 words, byte write enables, registered read
	sha_pkg::word_t blk_mem [16];
	sha_pkg::word_t blk_rd_q;
	logic [3:0]     blk_raddr;
	logic           blk_we;
	logic [5:0]     blk_waddr;
	logic [7:0]     blk_wdata;

	always_ff @(posedge clk) begin
		if (blk_we) begin
			case (blk_waddr[1:0])
				2'd0: blk_mem[blk_waddr[5:2]][31:24] <= blk_wdata;
				2'd1: blk_mem[blk_waddr[5:2]][23:16] <= blk_wdata;
				2'd2: blk_mem[blk_waddr[5:2]][15:8]  <= blk_wdata;
				2'd3: blk_mem[blk_waddr[5:2]][7:0]   <= blk_wdata;
				default: ;
			endcase
		end
		blk_rd_q <= blk_mem[blk_raddr];
	end

	sha_pkg::core_ctl_t ctl;
	sha_pkg::core_sts_t sts;
	sha_pkg::word_t     hash_new [8];
	logic               hash_we;

	sha_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.blk_addr (blk_raddr),
		.blk_word (blk_rd_q),
		.hash_in  (hash_q),
		.hash_out (hash_new),
		.hash_we  (hash_we)
	);

	logic [63:0] bit_len;
	assign bit_len = {count_q, 3'b000};

	logic acc;
	assign ready = (state_q == ST_IDLE);
	assign acc   = valid && ready;

	always_comb begin
		blk_we    = 1'b0;
		blk_waddr = fill_q;
		blk_wdata = data_byte;
		ctl.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					blk_we    = 1'b1;
					blk_wdata = (command == sha_pkg::CMD_FINISH) ? 8'h80 : data_byte;
					ctl.start = (fill_q == 6'd63);
				end
			end
			ST_PAD: begin
				blk_we    = 1'b1;
				blk_wdata = 8'h00;
				ctl.start = (fill_q == 6'd63);
			end
			ST_LEN: begin
				blk_we    = 1'b1;
				blk_waddr = {3'b111, len_q};
				blk_wdata = bit_len[8*(7-len_q) +: 8];
				ctl.start = (len_q == 3'd7);
			end
			default: ;
		endcase
	end

	logic [2:0] emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			fill_q    <= '0;
			two_q     <= 1'b0;
			len_q     <= '0;
			emit_q    <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::INIT_HASH[i];
		end else begin
			if (hash_we) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_new[i];
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						fill_q <= fill_q + 6'd1;
						if (command == sha_pkg::CMD_ABSORB) begin
							count_q <= count_q + 61'd1;
							if (fill_q == 6'd63) state_q <= ST_COMP;
						end else begin
							len_q <= '0;
							if (fill_q == 6'd63) begin
								two_q   <= 1'b1;
								state_q <= ST_FCOMP;
							end else if (fill_q == 6'd55) begin
								state_q <= ST_LEN;
							end else begin
								state_q <= ST_PAD;
							end
						end
					end
				end
				ST_COMP: begin
					if (sts.done) state_q <= ST_IDLE;
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						two_q   <= 1'b1;
						state_q <= ST_FCOMP;
					end else if (fill_q == 6'd55) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					len_q <= len_q + 3'd1;
					if (len_q == 3'd7) begin
						two_q   <= 1'b0;
						state_q <= ST_FCOMP;
					end
				end
				ST_FCOMP: begin
					if (sts.done) begin
						if (two_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q   <= ST_EMIT;
							emit_q    <= '0;
							out_valid <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_valid && out_ready) begin
						if (emit_q == 3'd7) begin
							out_valid <= 1'b0;
							state_q   <= ST_IDLE;
							count_q   <= '0;
							fill_q    <= '0;
							for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::INIT_HASH[i];
						end else begin
							emit_q <= emit_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign digest_word = hash_q[emit_q];
	assign word_index  = emit_q;
	assign last_word   = (emit_q == 3'd7);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_EMIT) else $error("digest outside emit");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !sts.busy) else $error("core restarted");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN) |-> fill_q == 6'd56) else $error("length misplaced");

endmodule
`default_nettype wire
